// File: design/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// Shared constants, result codes and controller/datapath interface types
// for the strip row packer.
// ----------------------------------------------------------------------------
package srp_pkg;

  // Atlas geometry
  localparam int ROW_WIDTH   = 2048;
  localparam int BORDER      = 4;
  localparam int ROW_COUNT   = 32;
  localparam int MAX_RESULTS = 8;
  localparam int STEP_BUDGET = 16;

  // Internal widths
  localparam int SPACE_W  = 12;  // space left and fill column, up to ROW_WIDTH
  localparam int ROW_W    = 6;   // current row, saturates at ROW_COUNT
  localparam int WIDTH_W  = 13;  // strip and piece width
  localparam int SRC_W    = 12;  // source coordinates
  localparam int TAG_W    = 8;
  localparam int STATUS_W = 2;
  localparam int ROWIDX_W = 5;
  localparam int COL_W    = 11;
  localparam int CNT_W    = 4;   // results emitted per strip, 0..MAX_RESULTS
  localparam int BUDGET_W = 5;   // row steps left per strip, 0..STEP_BUDGET

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PLACED     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ROWS_OUT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALPHA_LATE = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture input strip
    logic check;  // phase check: refuse or switch to solid phase
    logic split;  // one split step (piece in current row, advance row)
    logic fin;    // final placement of the remainder
  } srp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic refuse;    // alpha strip after solid phase
    logic split_go;  // strip does not fit and step/result budget remains
    logic out_free;  // output register can take a result this cycle
  } srp_stat_t;

endpackage

// File: design/srp_ctrl.sv
// ----------------------------------------------------------------------------
// srp_ctrl
// Sequencer for the strip row packer: accepts a strip, runs the phase check,
// then one split step or the final placement per cycle while output is free.
// ----------------------------------------------------------------------------
module srp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  srp_pkg::srp_stat_t stat_i,
  output srp_pkg::srp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_STEP  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        // a refused strip emits one beat, so it waits for the output register
        if (!stat_i.refuse || stat_i.out_free) begin
          cmd_o.check = 1'b1;
          state_d     = stat_i.refuse ? S_IDLE : S_STEP;
        end
      end
      S_STEP: begin
        if (stat_i.out_free) begin
          if (stat_i.split_go) begin
            cmd_o.split = 1'b1;
          end else begin
            cmd_o.fin = 1'b1;
            state_d   = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.check, cmd_o.split, cmd_o.fin}))
    else $error("srp_ctrl: more than one command issued");

endmodule

// File: design/srp_datapath.sv
// ----------------------------------------------------------------------------
// srp_datapath
// Packing state, strip registers, split/place arithmetic and the output
// result register of the strip row packer.
// ----------------------------------------------------------------------------
module srp_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srp_pkg::srp_cmd_t                   cmd_i,
  output srp_pkg::srp_stat_t                  stat_o,
  // input strip
  input  logic                                kind_i,
  input  logic [srp_pkg::WIDTH_W-1:0]         strip_width_i,
  input  logic [srp_pkg::SRC_W-1:0]           src_x_i,
  input  logic [srp_pkg::SRC_W-1:0]           src_y_i,
  input  logic [srp_pkg::TAG_W-1:0]           image_tag_i,
  // result
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [srp_pkg::STATUS_W-1:0]        status_o,
  output logic [srp_pkg::ROWIDX_W-1:0]        row_index_o,
  output logic [srp_pkg::COL_W-1:0]           column_o,
  output logic [srp_pkg::SRC_W-1:0]           piece_src_x_o,
  output logic [srp_pkg::SRC_W-1:0]           piece_src_y_o,
  output logic [srp_pkg::WIDTH_W-1:0]         piece_width_o,
  output logic [srp_pkg::TAG_W-1:0]           piece_tag_o,
  output logic                                last_o
);

  localparam logic [srp_pkg::SPACE_W-1:0] TWO_BORDERS = srp_pkg::SPACE_W'(2 * srp_pkg::BORDER);
  localparam logic [srp_pkg::SPACE_W-1:0] CAP_ALPHA   = srp_pkg::SPACE_W'(srp_pkg::ROW_WIDTH / 2);
  localparam logic [srp_pkg::SPACE_W-1:0] CAP_SOLID   = srp_pkg::SPACE_W'(srp_pkg::ROW_WIDTH);
  localparam logic [srp_pkg::ROW_W-1:0]   ROW_LIMIT   = srp_pkg::ROW_W'(srp_pkg::ROW_COUNT);

  // Packing state
  logic [srp_pkg::ROW_W-1:0]   row_q, row_d;
  logic [srp_pkg::SPACE_W-1:0] space_q, space_d;
  logic [srp_pkg::SPACE_W-1:0] fill_q, fill_d;
  logic                        solid_q, solid_d;
  // Strip in progress
  logic                        kind_q, kind_d;
  logic [srp_pkg::WIDTH_W-1:0] w_q, w_d;
  logic [srp_pkg::SRC_W-1:0]   x_q, x_d;
  logic [srp_pkg::SRC_W-1:0]   y_q, y_d;
  logic [srp_pkg::TAG_W-1:0]   tag_q, tag_d;
  logic [srp_pkg::CNT_W-1:0]   n_q, n_d;
  logic [srp_pkg::BUDGET_W-1:0] budget_q, budget_d;
  // Output register
  logic                         out_valid_q;
  logic [srp_pkg::STATUS_W-1:0] status_q;
  logic [srp_pkg::ROWIDX_W-1:0] row_index_q;
  logic [srp_pkg::COL_W-1:0]    column_q;
  logic [srp_pkg::SRC_W-1:0]    psx_q;
  logic [srp_pkg::SRC_W-1:0]    psy_q;
  logic [srp_pkg::WIDTH_W-1:0]  pw_q;
  logic [srp_pkg::TAG_W-1:0]    ptag_q;
  logic                         last_q;

  // Result being produced this cycle
  logic                         emit;
  logic [srp_pkg::STATUS_W-1:0] res_status;
  logic [srp_pkg::SRC_W-1:0]    res_x;
  logic [srp_pkg::WIDTH_W-1:0]  res_w;
  logic                         res_last;

  // Arithmetic
  logic [srp_pkg::SPACE_W-1:0]   cap;
  logic [srp_pkg::WIDTH_W:0]     need;       // width plus two borders
  logic                          no_fit;
  logic                          piece_pos;
  logic [srp_pkg::SPACE_W-1:0]   piece;
  logic [srp_pkg::WIDTH_W-1:0]   w_rest;
  logic                          rest_fits;
  logic [srp_pkg::SPACE_W-1:0]   space_after;
  logic [srp_pkg::ROW_W-1:0]     row_next;
  logic [srp_pkg::STATUS_W-1:0]  place_status;
  logic                          out_free;

  assign cap          = solid_q ? CAP_SOLID : CAP_ALPHA;
  assign need         = {1'b0, w_q} + (srp_pkg::WIDTH_W+1)'(TWO_BORDERS);
  assign no_fit       = need > {2'b00, space_q};
  assign piece_pos    = space_q > TWO_BORDERS;
  assign piece        = space_q - TWO_BORDERS;
  assign w_rest       = w_q - {1'b0, piece};
  // after a split the new row is empty, so the remainder fits iff it fits cap
  assign rest_fits    = ({1'b0, w_rest} + (srp_pkg::WIDTH_W+1)'(TWO_BORDERS))
                        <= {2'b00, cap};
  assign space_after  = space_q - need[srp_pkg::SPACE_W-1:0];
  assign row_next     = (row_q < ROW_LIMIT) ? row_q + 1'b1 : row_q;
  assign place_status = (row_q >= ROW_LIMIT) ? srp_pkg::ST_ROWS_OUT : srp_pkg::ST_PLACED;
  assign out_free     = !out_valid_q || !out_stall_i;

  // Status to controller
  assign stat_o.refuse   = !kind_q && solid_q;
  assign stat_o.split_go = no_fit && (budget_q != '0)
                           && (n_q < srp_pkg::CNT_W'(srp_pkg::MAX_RESULTS));
  assign stat_o.out_free = out_free;

  // Next-state logic for all commands
  always_comb begin
    row_d      = row_q;
    space_d    = space_q;
    fill_d     = fill_q;
    solid_d    = solid_q;
    kind_d     = kind_q;
    w_d        = w_q;
    x_d        = x_q;
    y_d        = y_q;
    tag_d      = tag_q;
    n_d        = n_q;
    budget_d   = budget_q;
    emit       = 1'b0;
    res_status = place_status;
    res_x      = x_q;
    res_w      = w_q;
    res_last   = 1'b1;

    if (cmd_i.load) begin
      kind_d   = kind_i;
      w_d      = strip_width_i;
      x_d      = src_x_i;
      y_d      = src_y_i;
      tag_d    = image_tag_i;
      n_d      = '0;
      budget_d = srp_pkg::BUDGET_W'(srp_pkg::STEP_BUDGET);
    end

    if (cmd_i.check) begin
      if (!kind_q && solid_q) begin
        // alpha strip too late: report current position, state untouched
        emit       = 1'b1;
        res_status = srp_pkg::ST_ALPHA_LATE;
        res_w      = '0;
      end else if (kind_q && !solid_q) begin
        solid_d = 1'b1;
        space_d = {space_q[srp_pkg::SPACE_W-2:0], 1'b0};
      end
    end

    if (cmd_i.split) begin
      budget_d = budget_q - 1'b1;
      if (piece_pos) begin
        emit     = 1'b1;
        res_w    = {1'b0, piece};
        // last if result limit reached, or steps run out and rest cannot go in
        res_last = (n_q == srp_pkg::CNT_W'(srp_pkg::MAX_RESULTS - 1))
                   || ((budget_q == srp_pkg::BUDGET_W'(1)) && !rest_fits);
        n_d      = n_q + 1'b1;
        x_d      = x_q + piece;
        w_d      = w_rest;
      end
      row_d   = row_next;
      space_d = cap;
      fill_d  = '0;
    end

    if (cmd_i.fin) begin
      if ((w_q != '0) && !no_fit && (n_q < srp_pkg::CNT_W'(srp_pkg::MAX_RESULTS))) begin
        emit    = 1'b1;
        n_d     = n_q + 1'b1;
        space_d = space_after;
        fill_d  = fill_q + need[srp_pkg::SPACE_W-1:0];
        if (space_after == '0) begin
          row_d   = row_next;
          space_d = cap;
          fill_d  = '0;
        end
      end
    end
  end

  // Packing and strip state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      space_q  <= CAP_ALPHA;
      fill_q   <= '0;
      solid_q  <= 1'b0;
      kind_q   <= 1'b0;
      n_q      <= '0;
      budget_q <= '0;
    end else begin
      row_q    <= row_d;
      space_q  <= space_d;
      fill_q   <= fill_d;
      solid_q  <= solid_d;
      kind_q   <= kind_d;
      n_q      <= n_d;
      budget_q <= budget_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    x_q   <= x_d;
    y_q   <= y_d;
    tag_q <= tag_d;
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q    <= res_status;
      row_index_q <= row_q[srp_pkg::ROWIDX_W-1:0];
      column_q    <= fill_q[srp_pkg::COL_W-1:0];
      psx_q       <= res_x;
      psy_q       <= y_q;
      pw_q        <= res_w;
      ptag_q      <= tag_q;
      last_q      <= res_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign row_index_o   = row_index_q;
  assign column_o      = column_q;
  assign piece_src_x_o = psx_q;
  assign piece_src_y_o = psy_q;
  assign piece_width_o = pw_q;
  assign piece_tag_o   = ptag_q;
  assign last_o        = last_q;

  // A result is only produced into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("srp_datapath: result overwrote a pending beat");

  // Row counter saturates at the row count
  a_row_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= ROW_LIMIT)
    else $error("srp_datapath: row counter past saturation");

  // Alpha phase never holds more than half a row
  a_alpha_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !solid_q |-> space_q <= CAP_ALPHA)
    else $error("srp_datapath: alpha phase space out of range");

  // Result count and step budget stay inside their limits
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q <= srp_pkg::CNT_W'(srp_pkg::MAX_RESULTS))
    && (budget_q <= srp_pkg::BUDGET_W'(srp_pkg::STEP_BUDGET)))
    else $error("srp_datapath: result count or step budget overflow");

endmodule

// File: design/strip_row_packer.sv
// ----------------------------------------------------------------------------
// strip_row_packer
// Packs alpha then solid image strips into fixed-width atlas rows, splitting
// strips across rows and emitting one placed piece per beat.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   strip   | in        | in_valid_i / in_stall_o | kind, width, src x/y, tag
//   piece   | out       | out_valid_o / out_stall_i | status, row, column, src
//           |           |                        | x/y, width, tag, last
//
// Sequence: a strip is accepted, then phase-checked (a refused strip ends
// there), then runs the row steps of the split loop and the final placement,
// one piece per cycle at most.
// Reset: asynchronous, active low; row 0, half a row free, alpha phase.
// Stalls: the output register holds one beat; a stalled output holds up every
// sequencer step that could emit a beat until the pending beat is taken.
// A new strip is taken once the previous one has produced all its beats.
// ----------------------------------------------------------------------------
module strip_row_packer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // strip in
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [srp_pkg::WIDTH_W-1:0]  strip_width_i,
  input  logic [srp_pkg::SRC_W-1:0]    src_x_i,
  input  logic [srp_pkg::SRC_W-1:0]    src_y_i,
  input  logic [srp_pkg::TAG_W-1:0]    image_tag_i,
  // piece out
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [srp_pkg::STATUS_W-1:0] status_o,
  output logic [srp_pkg::ROWIDX_W-1:0] row_index_o,
  output logic [srp_pkg::COL_W-1:0]    column_o,
  output logic [srp_pkg::SRC_W-1:0]    piece_src_x_o,
  output logic [srp_pkg::SRC_W-1:0]    piece_src_y_o,
  output logic [srp_pkg::WIDTH_W-1:0]  piece_width_o,
  output logic [srp_pkg::TAG_W-1:0]    piece_tag_o,
  output logic                         last_o
);

  srp_pkg::srp_cmd_t  cmd;
  srp_pkg::srp_stat_t stat;

  // Sequencer
  srp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Packing datapath and output register
  srp_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (kind_i),
    .strip_width_i (strip_width_i),
    .src_x_i       (src_x_i),
    .src_y_i       (src_y_i),
    .image_tag_i   (image_tag_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .row_index_o   (row_index_o),
    .column_o      (column_o),
    .piece_src_x_o (piece_src_x_o),
    .piece_src_y_o (piece_src_y_o),
    .piece_width_o (piece_width_o),
    .piece_tag_o   (piece_tag_o),
    .last_o        (last_o)
  );

endmodule

// File: verif/strip_piece_checker.sv
// ----------------------------------------------------------------------------
// strip_piece_checker
// Watches the strip and piece channels of the strip row packer. Each
// accepted strip is run through a behavioral packer that keeps its own row,
// space and phase state, and the pieces it predicts are queued. Each
// accepted piece beat is compared field by field with the oldest queued piece.
// ----------------------------------------------------------------------------
module strip_piece_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // strip channel
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic                                 kind_i,
  input  logic [srp_pkg::WIDTH_W-1:0]          strip_width_i,
  input  logic [srp_pkg::SRC_W-1:0]            src_x_i,
  input  logic [srp_pkg::SRC_W-1:0]            src_y_i,
  input  logic [srp_pkg::TAG_W-1:0]            image_tag_i,
  // piece channel
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic [srp_pkg::STATUS_W-1:0]         status_i,
  input  logic [srp_pkg::ROWIDX_W-1:0]         row_index_i,
  input  logic [srp_pkg::COL_W-1:0]            column_i,
  input  logic [srp_pkg::SRC_W-1:0]            piece_src_x_i,
  input  logic [srp_pkg::SRC_W-1:0]            piece_src_y_i,
  input  logic [srp_pkg::WIDTH_W-1:0]          piece_width_i,
  input  logic [srp_pkg::TAG_W-1:0]            piece_tag_i,
  input  logic                                 last_i,
  // to the testbench top
  output int                                   fail_count_o,
  output int                                   pieces_pending_o
);

  typedef struct packed {
    logic [srp_pkg::STATUS_W-1:0] status;
    logic [srp_pkg::ROWIDX_W-1:0] row_index;
    logic [srp_pkg::COL_W-1:0]    column;
    logic [srp_pkg::SRC_W-1:0]    src_x;
    logic [srp_pkg::SRC_W-1:0]    src_y;
    logic [srp_pkg::WIDTH_W-1:0]  width;
    logic [srp_pkg::TAG_W-1:0]    tag;
    logic                         last;
  } piece_t;

  // packer state as the predictor sees it
  int   row_now;
  int   room_left;
  int   fill_col;
  logic solid_on;

  piece_t pieces_due[$];
  int     errors;

  function automatic logic [srp_pkg::STATUS_W-1:0] place_code();
    return (row_now >= srp_pkg::ROW_COUNT) ? srp_pkg::ST_ROWS_OUT : srp_pkg::ST_PLACED;
  endfunction

  function automatic piece_t make_piece(logic [srp_pkg::STATUS_W-1:0] code,
                                        logic [srp_pkg::SRC_W-1:0] x,
                                        logic [srp_pkg::SRC_W-1:0] y, int w,
                                        logic [srp_pkg::TAG_W-1:0] tag);
    piece_t p;
    p.status    = code;
    p.row_index = row_now[srp_pkg::ROWIDX_W-1:0];
    p.column    = fill_col[srp_pkg::COL_W-1:0];
    p.src_x     = x;
    p.src_y     = y;
    p.width     = srp_pkg::WIDTH_W'(w);
    p.tag       = tag;
    p.last      = 1'b0;
    return p;
  endfunction

  // close the current row; the row number saturates at ROW_COUNT
  task automatic next_row();
    if (row_now < srp_pkg::ROW_COUNT) row_now++;
    room_left = solid_on ? srp_pkg::ROW_WIDTH : srp_pkg::ROW_WIDTH / 2;
    fill_col  = 0;
  endtask

  // predict the pieces of one strip and queue them
  task automatic place_strip(input logic solid, input int w_in,
                             input logic [srp_pkg::SRC_W-1:0] x_in,
                             input logic [srp_pkg::SRC_W-1:0] y_in,
                             input logic [srp_pkg::TAG_W-1:0] tag_in);
    int                        w;
    int                        piece;
    int                        steps;
    logic [srp_pkg::SRC_W-1:0] x;
    piece_t                    batch[$];
    w     = w_in;
    x     = x_in;
    steps = srp_pkg::STEP_BUDGET;
    if (!solid && solid_on) begin
      // alpha strips are refused once the solid phase has begun
      batch.insert(batch.size(), make_piece(srp_pkg::ST_ALPHA_LATE, x, y_in, 0, tag_in));
    end else begin
      // first solid strip: alpha cost was double, so the free space doubles
      if (solid && !solid_on) begin
        solid_on  = 1'b1;
        room_left = room_left * 2;
      end
      // split while the strip plus borders overflows the row
      while (w + 2 * srp_pkg::BORDER > room_left && steps > 0
             && batch.size() < srp_pkg::MAX_RESULTS) begin
        piece = room_left - 2 * srp_pkg::BORDER;
        steps--;
        // an empty first piece leaves the strip as it is
        if (piece > 0) begin
          batch.insert(batch.size(), make_piece(place_code(), x, y_in, piece, tag_in));
          x = x + srp_pkg::SRC_W'(piece);
          w = w - piece;
        end
        next_row();
      end
      // remainder fits in the current row
      if (w > 0 && w + 2 * srp_pkg::BORDER <= room_left
          && batch.size() < srp_pkg::MAX_RESULTS) begin
        batch.insert(batch.size(), make_piece(place_code(), x, y_in, w, tag_in));
        room_left = room_left - (w + 2 * srp_pkg::BORDER);
        fill_col  = fill_col + w + 2 * srp_pkg::BORDER;
        if (room_left <= 0) next_row();
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) pieces_due.insert(pieces_due.size(), batch[i]);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: piece %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    piece_t want;
    if (!rst_ni) begin
      row_now          = 0;
      room_left        = srp_pkg::ROW_WIDTH / 2;
      fill_col         = 0;
      solid_on         = 1'b0;
      errors           = 0;
      pieces_due.delete();
      fail_count_o     <= 0;
      pieces_pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        place_strip(kind_i, int'(strip_width_i), src_x_i, src_y_i, image_tag_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pieces_due.size() == 0) begin
          $display("%0t: unexpected piece beat, expected none, got width %0d tag %0d",
                   $time, piece_width_i, piece_tag_i);
          errors++;
        end else begin
          want = pieces_due.pop_front();
          check_field("status", want.status, status_i);
          check_field("row_index", want.row_index, row_index_i);
          check_field("column", want.column, column_i);
          check_field("src_x", want.src_x, piece_src_x_i);
          check_field("src_y", want.src_y, piece_src_y_i);
          check_field("width", want.width, piece_width_i);
          check_field("tag", want.tag, piece_tag_i);
          check_field("last", want.last, last_i);
        end
      end
      fail_count_o     <= errors;
      pieces_pending_o <= pieces_due.size();
    end
  end

endmodule

// File: verif/strip_row_packer_tb.sv
// ----------------------------------------------------------------------------
// strip_row_packer_tb
// Drives strips into the strip row packer: a directed pass through the alpha
// phase (zero width, exact fits, empty first piece, source wrap, piece cap),
// random alpha strips, the switch to the solid phase with a refused alpha
// strip, random mixed strips, and a tail that runs the atlas out of rows.
// Both channels idle and stall at random; the checker does the comparing.
// ----------------------------------------------------------------------------
module strip_row_packer_tb;

  localparam logic KIND_ALPHA   = 1'b0;
  localparam logic KIND_SOLID   = 1'b1;
  localparam int   MAX_IDLE     = 6;
  localparam int   DRAIN_CYCLES = 64;
  localparam int   LIMIT_CYCLES = 200000;
  localparam int   FULL_WIDTH   = 8191;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_stall_o;
  logic                                 kind_i;
  logic [srp_pkg::WIDTH_W-1:0]          strip_width_i;
  logic [srp_pkg::SRC_W-1:0]            src_x_i;
  logic [srp_pkg::SRC_W-1:0]            src_y_i;
  logic [srp_pkg::TAG_W-1:0]            image_tag_i;
  logic                                 out_valid_o;
  logic                                 out_stall_i;
  logic [srp_pkg::STATUS_W-1:0]         status_o;
  logic [srp_pkg::ROWIDX_W-1:0]         row_index_o;
  logic [srp_pkg::COL_W-1:0]            column_o;
  logic [srp_pkg::SRC_W-1:0]            piece_src_x_o;
  logic [srp_pkg::SRC_W-1:0]            piece_src_y_o;
  logic [srp_pkg::WIDTH_W-1:0]          piece_width_o;
  logic [srp_pkg::TAG_W-1:0]            piece_tag_o;
  logic                                 last_o;

  int fail_count;
  int pieces_pending;
  int cycles = 0;
  int strips_sent = 0;
  bit strip_gaps_on = 1'b1;

  always #1 clk_i = ~clk_i;

  strip_row_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .strip_width_i (strip_width_i),
    .src_x_i       (src_x_i),
    .src_y_i       (src_y_i),
    .image_tag_i   (image_tag_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .row_index_o   (row_index_o),
    .column_o      (column_o),
    .piece_src_x_o (piece_src_x_o),
    .piece_src_y_o (piece_src_y_o),
    .piece_width_o (piece_width_o),
    .piece_tag_o   (piece_tag_o),
    .last_o        (last_o)
  );

  strip_piece_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .kind_i           (kind_i),
    .strip_width_i    (strip_width_i),
    .src_x_i          (src_x_i),
    .src_y_i          (src_y_i),
    .image_tag_i      (image_tag_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_i         (status_o),
    .row_index_i      (row_index_o),
    .column_i         (column_o),
    .piece_src_x_i    (piece_src_x_o),
    .piece_src_y_i    (piece_src_y_o),
    .piece_width_i    (piece_width_o),
    .piece_tag_i      (piece_tag_o),
    .last_i           (last_o),
    .fail_count_o     (fail_count),
    .pieces_pending_o (pieces_pending)
  );

  // one strip beat: optional gap, then hold valid until accepted;
  // entered and left on a rising edge
  task automatic send_strip(input logic kind, input logic [srp_pkg::WIDTH_W-1:0] w,
                            input logic [srp_pkg::SRC_W-1:0] x,
                            input logic [srp_pkg::SRC_W-1:0] y,
                            input logic [srp_pkg::TAG_W-1:0] tag);
    int gap;
    if (strips_sent % 16 == 0) strip_gaps_on = ($urandom_range(0, 3) != 0);
    strips_sent++;
    gap = strip_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    strip_width_i <= w;
    src_x_i       <= x;
    src_y_i       <= y;
    image_tag_i   <= tag;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // mostly short strips so rows last, some up to a row, a few of any width;
  // half are rounded to whole borders so rows can end exactly
  function automatic logic [srp_pkg::WIDTH_W-1:0] draw_width();
    int r;
    int w;
    r = $urandom_range(0, 99);
    if (r < 70) w = $urandom_range(1, 256);
    else if (r < 88) w = $urandom_range(1, srp_pkg::ROW_WIDTH);
    else w = $urandom_range(0, FULL_WIDTH);
    if ($urandom_range(0, 1)) w = (w / srp_pkg::BORDER) * srp_pkg::BORDER;
    return srp_pkg::WIDTH_W'(w);
  endfunction

  task automatic send_random(input logic kind);
    send_strip(kind, draw_width(), srp_pkg::SRC_W'($urandom), srp_pkg::SRC_W'($urandom),
               srp_pkg::TAG_W'($urandom));
  endtask

  // piece side: stall for a drawn number of cycles, then take one beat
  initial begin
    int  gap;
    int  beats;
    bit  stalls_on;
    beats     = 0;
    stalls_on = 1'b1;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (beats % 20 == 0) stalls_on = ($urandom_range(0, 3) != 0);
      gap = stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      beats++;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("FAIL strip_row_packer");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_ALPHA;
    strip_width_i = '0;
    src_x_i       = '0;
    src_y_i       = '0;
    image_tag_i   = '0;
    out_stall_i   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // alpha phase: half-width rows
    send_strip(KIND_ALPHA, 0, 0, 0, 0);                 // zero width, nothing out
    send_strip(KIND_ALPHA, 1016, 4095, 4095, 255);      // fills row 0 exactly
    send_strip(KIND_ALPHA, 1012, 1, 2, 3);              // leaves one border free
    send_strip(KIND_ALPHA, 4, 5, 6, 7);                 // empty first piece
    send_strip(KIND_ALPHA, 2000, 4000, 100, 8);         // split, source x wraps
    send_strip(KIND_ALPHA, 12, 9, 9, 9);                // exact fit closes row
    send_strip(KIND_ALPHA, FULL_WIDTH, 4095, 0, 128);   // hits the piece cap
    repeat (20) send_random(KIND_ALPHA);

    // solid phase begins; alpha refused from here on
    send_strip(KIND_SOLID, 100, 0, 4095, 1);
    send_strip(KIND_ALPHA, 500, 77, 88, 200);
    send_strip(KIND_SOLID, 0, 3, 3, 3);
    repeat (92) send_random(($urandom_range(0, 9) < 8) ? KIND_SOLID : KIND_ALPHA);

    // run the atlas out of rows, then place past the end
    repeat (5) send_strip(KIND_SOLID, FULL_WIDTH, 2048, 1024, 64);
    send_strip(KIND_SOLID, 16, 10, 11, 12);
    send_strip(KIND_SOLID, 16, 4095, 4095, 255);
    send_strip(KIND_ALPHA, 16, 20, 21, 22);
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (pieces_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pieces_pending == 0) begin
      $display("PASS strip_row_packer");
    end else begin
      $display("FAIL strip_row_packer");
    end
    $finish;
  end

endmodule

// File: sim.f
design/srp_pkg.sv
design/srp_ctrl.sv
design/srp_datapath.sv
design/strip_row_packer.sv
verif/strip_piece_checker.sv
verif/strip_row_packer_tb.sv
